// ===== hdl/software_timer_table_top_defines.svh =====
// ----------------------------------------------------------------------------
// software timer table assertion macros
// concurrent assertion helpers clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef SOFTWARE_TIMER_TABLE_TOP_DEFINES_SVH
`define SOFTWARE_TIMER_TABLE_TOP_DEFINES_SVH

// same-cycle implication
`define STT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define STT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/stt_pkg.sv =====
// ----------------------------------------------------------------------------
// stt_pkg
// command codes, status codes and beat types of the software timer table
// ----------------------------------------------------------------------------
`default_nettype none

package stt_pkg;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_MODIFY = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_TICK   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_ADDED     = 3'd0,
    ST_FULL      = 3'd1,
    ST_OK        = 3'd2,
    ST_BAD_ID    = 3'd3,
    ST_EXPIRED   = 3'd4,
    ST_TICK_NONE = 3'd5
  } status_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [4:0]  timer_id;
    logic [31:0] duration_ms;
    logic        periodic;
    logic [15:0] elapsed_ms;
  } cmd_beat_t;

  typedef struct packed {
    status_t     status;
    logic [4:0]  slot_id;
    logic [31:0] interval_ms;
    logic        last;
  } res_beat_t;

endpackage

`default_nettype wire

// ===== hdl/stt_ram.sv =====
// ----------------------------------------------------------------------------
// stt_ram
// simple dual-port ram, one write port and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module stt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                        wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hdl/software_timer_table_top.sv =====
// ----------------------------------------------------------------------------
// software_timer_table_top
// timer slot table with a 64-bit millisecond clock and a slot sequencer
// ----------------------------------------------------------------------------
// usage:
//   cmd channel (cmd_valid/cmd_ready/cmd_data) takes one command beat at a
//   time; res channel (res_valid/res_ready/res_data) returns result beats,
//   the final beat of a command carries last = 1.
//   add walks the live bits one slot a cycle.
//   modify and remove pass S_SINGLE and S_PUSH to the result register.
//   tick adds elapsed_ms to the clock, then walks the slots: S_TICK_SCAN
//   skips a free slot; a live slot passes S_TICK_SCAN (ram read), S_TICK_CALC
//   (64-bit add and subtract) and S_TICK_EVAL (compare, held while an earlier
//   beat waits on the output); the final beat leaves through S_PUSH.
//   cmd_ready is high only while the sequencer is idle; the next command
//   can enter while the final result still waits in the output register.
//   reset clears the clock and all live and periodic bits; the slot rams
//   are not cleared, a slot is written in full when it is added.
//   when res_ready is low the sequencer holds on the next result beat.
// ----------------------------------------------------------------------------
`default_nettype none
`include "software_timer_table_top_defines.svh"

module software_timer_table_top #(
  parameter int TIMER_SLOTS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cmd_valid,
  output logic                    cmd_ready,
  input  wire stt_pkg::cmd_beat_t cmd_data,
  output logic                    res_valid,
  input  wire logic               res_ready,
  output stt_pkg::res_beat_t      res_data
);

  localparam int IW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int CW = $clog2(TIMER_SLOTS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD_SCAN,
    S_SINGLE,
    S_TICK_SCAN,
    S_TICK_CALC,
    S_TICK_EVAL,
    S_PUSH
  } state_t;

  state_t             state;
  stt_pkg::cmd_beat_t item;
  stt_pkg::res_beat_t pend;
  logic               pend_valid;
  logic [CW-1:0]      idx;
  logic [63:0]        clock_ms;
  logic [TIMER_SLOTS-1:0] live;
  logic [TIMER_SLOTS-1:0] per;
  logic [63:0]        sum;
  logic [63:0]        diff;

  logic [IW-1:0] slot;
  logic [IW-1:0] sid;
  logic [IW-1:0] waddr;
  logic          scan_done;
  logic          bad_id;
  logic          out_free;
  logic          add_take;
  logic          expired;
  logic          eval_go;
  logic          res_load;
  logic [31:0]   ival;
  logic [4:0]    idx_id;
  logic          dur_we;
  logic          start_we;
  logic          last_we;
  logic [31:0]   rd_dur;
  logic [63:0]   rd_start;
  logic [63:0]   rd_last;

  assign cmd_ready = (state == S_IDLE);
  assign slot      = idx[IW-1:0];
  assign sid       = IW'(item.timer_id - 5'd1);
  assign scan_done = (idx == CW'(TIMER_SLOTS));
  assign bad_id    = (item.timer_id == 5'd0) || ({2'b00, item.timer_id} > 7'(TIMER_SLOTS));
  assign out_free  = !res_valid || res_ready;
  assign add_take  = (state == S_ADD_SCAN) && !scan_done && !live[slot];
  assign expired   = (sum <= clock_ms);
  assign eval_go   = (state == S_TICK_EVAL) && expired && (!pend_valid || out_free);
  assign res_load  = (eval_go && pend_valid) || ((state == S_PUSH) && out_free);
  assign ival      = (diff[63:32] != 32'd0) ? 32'hFFFF_FFFF : diff[31:0];
  assign idx_id    = 5'(idx + CW'(1));

  always_comb begin
    dur_we   = add_take ||
               ((state == S_SINGLE) && !bad_id && live[sid] &&
                (item.cmd == stt_pkg::CMD_MODIFY));
    start_we = add_take || (eval_go && per[slot]);
    last_we  = add_take || (state == S_TICK_CALC);
    waddr    = (state == S_SINGLE) ? sid : slot;
  end

  stt_ram #(.WIDTH(32), .DEPTH(TIMER_SLOTS)) u_dur_ram (
    .clk   (clk),
    .we    (dur_we),
    .waddr (waddr),
    .wdata (item.duration_ms),
    .raddr (slot),
    .rdata (rd_dur)
  );

  stt_ram #(.WIDTH(64), .DEPTH(TIMER_SLOTS)) u_start_ram (
    .clk   (clk),
    .we    (start_we),
    .waddr (waddr),
    .wdata (clock_ms),
    .raddr (slot),
    .rdata (rd_start)
  );

  stt_ram #(.WIDTH(64), .DEPTH(TIMER_SLOTS)) u_last_ram (
    .clk   (clk),
    .we    (last_we),
    .waddr (waddr),
    .wdata (clock_ms),
    .raddr (slot),
    .rdata (rd_last)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      res_valid  <= 1'b0;
      pend_valid <= 1'b0;
      clock_ms   <= 64'd0;
      live       <= '0;
      per        <= '0;
    end else begin
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_valid && res_ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            item       <= cmd_data;
            idx        <= '0;
            pend_valid <= 1'b0;
            case (cmd_data.cmd)
              stt_pkg::CMD_ADD: state <= S_ADD_SCAN;
              stt_pkg::CMD_TICK: begin
                clock_ms <= clock_ms + 64'(cmd_data.elapsed_ms);
                state    <= S_TICK_SCAN;
              end
              default: state <= S_SINGLE;
            endcase
          end
        end
        S_ADD_SCAN: begin
          if (scan_done) begin
            pend  <= '{status: stt_pkg::ST_FULL, slot_id: 5'd0, interval_ms: 32'd0,
                       last: 1'b1};
            state <= S_PUSH;
          end else if (!live[slot]) begin
            live[slot] <= 1'b1;
            per[slot]  <= item.periodic;
            pend  <= '{status: stt_pkg::ST_ADDED, slot_id: idx_id, interval_ms: 32'd0,
                       last: 1'b1};
            state <= S_PUSH;
          end else begin
            idx <= idx + CW'(1);
          end
        end
        S_SINGLE: begin
          if (bad_id) begin
            pend <= '{status: stt_pkg::ST_BAD_ID, slot_id: 5'd0, interval_ms: 32'd0,
                      last: 1'b1};
          end else begin
            if (live[sid] && (item.cmd == stt_pkg::CMD_REMOVE)) begin
              live[sid] <= 1'b0;
              per[sid]  <= 1'b0;
            end
            pend <= '{status: stt_pkg::ST_OK, slot_id: 5'd0, interval_ms: 32'd0,
                      last: 1'b1};
          end
          state <= S_PUSH;
        end
        S_TICK_SCAN: begin
          if (scan_done) begin
            if (!pend_valid) begin
              pend <= '{status: stt_pkg::ST_TICK_NONE, slot_id: 5'd0, interval_ms: 32'd0,
                        last: 1'b1};
            end
            state <= S_PUSH;
          end else if (live[slot]) begin
            state <= S_TICK_CALC;
          end else begin
            idx <= idx + CW'(1);
          end
        end
        S_TICK_CALC: begin
          sum   <= rd_start + 64'(rd_dur);
          diff  <= clock_ms - rd_last;
          state <= S_TICK_EVAL;
        end
        S_TICK_EVAL: begin
          if (!expired) begin
            idx   <= idx + CW'(1);
            state <= S_TICK_SCAN;
          end else if (eval_go) begin
            if (pend_valid) begin
              res_data  <= '{status: pend.status, slot_id: pend.slot_id,
                             interval_ms: pend.interval_ms, last: 1'b0};
            end
            if (!per[slot]) begin
              live[slot] <= 1'b0;
            end
            pend       <= '{status: stt_pkg::ST_EXPIRED, slot_id: idx_id, interval_ms: ival,
                            last: 1'b1};
            pend_valid <= 1'b1;
            idx        <= idx + CW'(1);
            state      <= S_TICK_SCAN;
          end
        end
        S_PUSH: begin
          if (out_free) begin
            res_data  <= '{status: pend.status, slot_id: pend.slot_id,
                           interval_ms: pend.interval_ms, last: 1'b1};
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `STT_ASSERT_NEXT(a_busy_after_accept, cmd_valid && cmd_ready, !cmd_ready, "accepted command did not leave idle")
  `STT_ASSERT_NOW(a_single_is_last, res_valid && (res_data.status != stt_pkg::ST_EXPIRED), res_data.last, "non-expiry result without last")
  `STT_ASSERT_NEXT(a_clock_holds, state != S_IDLE, $stable(clock_ms), "clock moved outside a tick accept")
  `STT_ASSERT_NOW(a_eval_live, (state == S_TICK_CALC) || (state == S_TICK_EVAL), live[slot], "evaluating a free slot")

endmodule

`default_nettype wire
